>>> hw/rtl/hmap_pkg.sv
`default_nettype none
package hmap_pkg;

	// Number of slots in the table.
	localparam int unsigned CAPACITY = 16;

	// Slot index width, and a counter wide enough to hold CAPACITY itself.
	localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

	// Power-of-two capacity lets the start index be a mask of the hash.
	localparam bit CAP_POW2 = ((CAPACITY & (CAPACITY - 1)) == 0);

	// Load mark: used * 4 >= CAPACITY * 3.
	localparam int unsigned LOAD_MARK = CAPACITY * 3;

	// One slot word: {hash, key, value}.
	localparam int unsigned WORD_W = 64;
	localparam int unsigned SLOT_W = 3 * WORD_W;

	// Request selector codes.
	localparam logic MODE_GET = 1'b0;
	localparam logic MODE_PUT = 1'b1;

endpackage
`default_nettype wire

>>> hw/rtl/hmap_ram.sv
`default_nettype none
module hmap_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                                       clk,
	input  wire logic                                       we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                           wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

>>> hw/rtl/hmap_mod.sv
`default_nettype none
// Start index: hash modulo CAPACITY.
// Power of two: registered mask. Otherwise: bit-serial remainder, 8 bits/cycle.
module hmap_mod
	import hmap_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [WORD_W-1:0] hash,
	output logic                   done,
	output logic      [IDX_W-1:0]  rem
);

	generate
		if (CAP_POW2) begin : g_mask
			logic             done_q;
			logic [IDX_W-1:0] rem_q;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
				end else begin
					done_q <= start;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					rem_q <= hash[IDX_W-1:0];
				end
			end

			assign done = done_q;
			assign rem  = rem_q;
		end else begin : g_serial
			localparam int unsigned BITS_PER_CYC = 8;
			localparam int unsigned ROUNDS       = WORD_W / BITS_PER_CYC;
			localparam int unsigned RND_W        = $clog2(ROUNDS + 1);

			logic [WORD_W-1:0] sh_q;
			logic [IDX_W-1:0]  r_q;
			logic [RND_W-1:0]  left_q;
			logic              done_q;
			logic [IDX_W-1:0]  r_n;

			// Restoring step per bit: r = 2r + bit, minus CAPACITY if it overflows.
			always_comb begin
				logic [IDX_W:0] t;
				t   = '0;
				r_n = r_q;
				for (int i = 0; i < BITS_PER_CYC; i++) begin
					t = {r_n, sh_q[WORD_W-1-i]};
					if (t >= (IDX_W+1)'(CAPACITY)) begin
						t = t - (IDX_W+1)'(CAPACITY);
					end
					r_n = t[IDX_W-1:0];
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					left_q <= '0;
					done_q <= 1'b0;
				end else if (start) begin
					left_q <= RND_W'(ROUNDS);
					done_q <= 1'b0;
				end else if (left_q != '0) begin
					left_q <= left_q - RND_W'(1);
					done_q <= (left_q == RND_W'(1));
				end else begin
					done_q <= 1'b0;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					sh_q <= hash;
					r_q  <= '0;
				end else if (left_q != '0) begin
					sh_q <= sh_q << BITS_PER_CYC;
					r_q  <= r_n;
				end
			end

			assign done = done_q;
			assign rem  = r_q;
		end
	endgenerate

endmodule
`default_nettype wire

>>> hw/rtl/open_addressed_hash_map_core.sv
`default_nettype none
// Channel   Beat carries                                         Handshake
// req       mode, key, key_hash, new_value, default_value        req_valid / req_stall
// rsp       result_value, found, table_full, load_high           rsp_valid / rsp_stall
//
// One request at a time. A request passes the start index (ST_HASH), then a read and a
// check per probe (ST_READ, ST_CHECK) for p probes, p from 1 to CAPACITY, then the
// hand-off (ST_DONE); the next request is taken once the core is back in ST_IDLE. The
// slot RAM has a registered read, which is why each probe reads and then decides. A
// non-power-of-two capacity finds the start index by a serial remainder of the hash.
// Reset clears the slot used bits and the used count at once; key and value words in the
// RAM are never cleared and are only read behind a set used bit.
// A stalled response sits in the output register; the next request is still taken.
module open_addressed_hash_map_core
	import hmap_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	// request
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire logic              mode,
	input  wire logic [WORD_W-1:0] key,
	input  wire logic [WORD_W-1:0] key_hash,
	input  wire logic [WORD_W-1:0] new_value,
	input  wire logic [WORD_W-1:0] default_value,
	// response
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output logic      [WORD_W-1:0] result_value,
	output logic                   found,
	output logic                   table_full,
	output logic                   load_high
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_HASH  = 5'b00010,
		ST_READ  = 5'b00100,
		ST_CHECK = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t state_q;

	// request held for the whole probe
	logic              mode_q;
	logic [WORD_W-1:0] key_q;
	logic [WORD_W-1:0] hash_q;
	logic [WORD_W-1:0] nval_q;
	logic [WORD_W-1:0] dval_q;

	// probe position
	logic [IDX_W-1:0]  idx_q;
	logic [CNT_W-1:0]  step_q;

	// table bookkeeping
	logic [CAPACITY-1:0] used_q;
	logic [CNT_W-1:0]    cnt_q;

	// pending result
	logic [WORD_W-1:0] res_val_q;
	logic              res_found_q;
	logic              res_full_q;

	// output register
	logic              rsp_valid_q;
	logic [WORD_W-1:0] rsp_val_q;
	logic              rsp_found_q;
	logic              rsp_full_q;
	logic              rsp_load_q;

	logic              req_acc;
	logic [WORD_W-1:0] hash_in;
	logic              mod_done;
	logic [IDX_W-1:0]  mod_rem;

	logic              ram_we;
	logic [SLOT_W-1:0] ram_wdata;
	logic [SLOT_W-1:0] ram_rdata;

	logic [WORD_W-1:0] slot_hash;
	logic [WORD_W-1:0] slot_key;
	logic [WORD_W-1:0] slot_val;
	logic              slot_used;
	logic              slot_hit;
	logic [CNT_W-1:0]  step_n;
	logic              probe_last;
	logic [IDX_W:0]    idx_sum;
	logic [IDX_W-1:0]  idx_n;
	logic              out_free;

	assign req_stall = (state_q != ST_IDLE);
	assign req_acc   = req_valid && !req_stall;

	// a zero hash probes as one; never-used slots are marked by the used bits
	assign hash_in = (key_hash == '0) ? WORD_W'(1) : key_hash;

	hmap_mod u_mod (
		.clk   (clk),
		.arst_n(arst_n),
		.start (req_acc),
		.hash  (hash_in),
		.done  (mod_done),
		.rem   (mod_rem)
	);

	// One RAM holds {hash, key, value} per slot; read address tracks idx_q, so the word
	// for the current slot is ready in ST_CHECK. Only one request is in flight and its
	// write lands in ST_CHECK, well before any later read of that slot.
	hmap_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(CAPACITY)
	) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(idx_q),
		.wdata(ram_wdata),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	assign slot_hash = ram_rdata[3*WORD_W-1:2*WORD_W];
	assign slot_key  = ram_rdata[2*WORD_W-1:WORD_W];
	assign slot_val  = ram_rdata[WORD_W-1:0];
	assign slot_used = used_q[idx_q];
	assign slot_hit  = slot_used && (slot_hash == hash_q) && (slot_key == key_q);

	// put writes on a free slot or a matching key; the word is the same either way
	assign ram_we    = (state_q == ST_CHECK) && (mode_q == MODE_PUT) && (!slot_used || slot_hit);
	assign ram_wdata = {hash_q, key_q, nval_q};

	// triangular step: next index = (idx + step + 1) mod CAPACITY, sum stays below 2*CAPACITY
	assign step_n     = step_q + CNT_W'(1);
	assign probe_last = (step_n == CNT_W'(CAPACITY));
	assign idx_sum    = (IDX_W+1)'(idx_q) + (IDX_W+1)'(step_n);
	assign idx_n      = (idx_sum >= (IDX_W+1)'(CAPACITY)) ?
	                    IDX_W'(idx_sum - (IDX_W+1)'(CAPACITY)) : idx_sum[IDX_W-1:0];

	assign out_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			used_q  <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						state_q <= ST_HASH;
					end
				end
				ST_HASH: begin
					if (mod_done) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (!slot_used || slot_hit || probe_last) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_READ;
					end
					if (!slot_used && (mode_q == MODE_PUT)) begin
						used_q[idx_q] <= 1'b1;
						cnt_q         <= cnt_q + CNT_W'(1);
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request capture, probe position and result
	always_ff @(posedge clk) begin
		if (req_acc) begin
			mode_q <= mode;
			key_q  <= key;
			hash_q <= hash_in;
			nval_q <= new_value;
			dval_q <= default_value;
		end
		if (state_q == ST_HASH && mod_done) begin
			idx_q  <= mod_rem;
			step_q <= '0;
		end
		if (state_q == ST_CHECK) begin
			if (!(!slot_used || slot_hit || probe_last)) begin
				idx_q  <= idx_n;
				step_q <= step_n;
			end
			res_full_q <= 1'b0;
			if (mode_q == MODE_PUT) begin
				if (!slot_used || slot_hit) begin
					res_val_q   <= nval_q;
					res_found_q <= 1'b1;
				end else begin
					// used slot, other key: full unless a later probe finds a free or matching slot; nothing written
					res_val_q   <= '0;
					res_found_q <= 1'b0;
					res_full_q  <= 1'b1;
				end
			end else begin
				res_val_q   <= slot_hit ? slot_val : dval_q;
				res_found_q <= slot_hit;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// load flag uses the count after this request, already settled in ST_DONE
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			rsp_val_q   <= res_val_q;
			rsp_found_q <= res_found_q;
			rsp_full_q  <= res_full_q;
			rsp_load_q  <= ({cnt_q, 2'b00} >= (CNT_W+2)'(LOAD_MARK));
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign result_value = rsp_val_q;
	assign found        = rsp_found_q;
	assign table_full   = rsp_full_q;
	assign load_high    = rsp_load_q;

	// used count tracks the used bits
	a_cnt_matches: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == CNT_W'($countones(used_q)))
		else $error("used count out of step with used bits");

	// slot RAM written only while deciding a put
	a_write_in_put: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_CHECK) && (mode_q == MODE_PUT))
		else $error("slot write outside a put decision");

	// a full table never also reports success, and answers zero
	a_full_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && table_full) |-> (!found && (result_value == '0)))
		else $error("table_full beat with found or nonzero value");

	// a used bit only ever goes up
	a_used_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |=> ((used_q & $past(used_q)) == $past(used_q)))
		else $error("used bit cleared");

endmodule
`default_nettype wire

>>> test/hmap_checker.sv
`timescale 1ns / 1ps

// Watches both channels. Keeps a private copy of the table and checks each
// response beat against the oldest prediction.
module hmap_checker
	import hmap_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_stall,
	input  logic              mode,
	input  logic [WORD_W-1:0] key,
	input  logic [WORD_W-1:0] key_hash,
	input  logic [WORD_W-1:0] new_value,
	input  logic [WORD_W-1:0] default_value,
	input  logic              rsp_valid,
	input  logic              rsp_stall,
	input  logic [WORD_W-1:0] result_value,
	input  logic              found,
	input  logic              table_full,
	input  logic              load_high,
	output int                fail_cnt,
	output int                pending_cnt
);

	typedef struct packed {
		logic [WORD_W-1:0] value;
		logic              hit;
		logic              full;
		logic              load;
	} map_answer_t;

	logic [WORD_W-1:0] slot_hash [CAPACITY];
	logic [WORD_W-1:0] slot_key  [CAPACITY];
	logic [WORD_W-1:0] slot_val  [CAPACITY];
	int unsigned       used_slots;
	map_answer_t       answer_q [$];
	map_answer_t       want;

	initial begin
		fail_cnt    = 0;
		pending_cnt = 0;
	end

	// Triangular probe over the private table; updates it for puts.
	function automatic map_answer_t probe_table(input logic m, input logic [WORD_W-1:0] k,
			input logic [WORD_W-1:0] h_in, input logic [WORD_W-1:0] nv,
			input logic [WORD_W-1:0] dv);
		logic [WORD_W-1:0] h;
		int unsigned       idx;
		int unsigned       step;
		bit                done;
		map_answer_t       a;
		h    = (h_in == '0) ? 64'd1 : h_in;
		idx  = int'(h % CAPACITY);
		a    = '0;
		done = 1'b0;
		for (step = 0; step < CAPACITY && !done; step++) begin
			if (step != 0)
				idx = (idx + step) % CAPACITY;
			if (slot_hash[idx] == '0) begin
				if (m == MODE_PUT) begin
					slot_hash[idx] = h;
					slot_key[idx]  = k;
					slot_val[idx]  = nv;
					used_slots++;
					a.value = nv;
					a.hit   = 1'b1;
				end
				done = 1'b1;
			end else if (slot_hash[idx] == h && slot_key[idx] == k) begin
				if (m == MODE_PUT) begin
					slot_val[idx] = nv;
					a.value = nv;
				end else begin
					a.value = slot_val[idx];
				end
				a.hit = 1'b1;
				done  = 1'b1;
			end
		end
		if (m == MODE_GET && !a.hit)
			a.value = dv;
		if (m == MODE_PUT && !done) begin
			a.full  = 1'b1;
			a.value = '0;
		end
		a.load = (used_slots * 4 >= LOAD_MARK);
		return a;
	endfunction

	function automatic void check_word(input string what, input logic [WORD_W-1:0] exp_v,
			input logic [WORD_W-1:0] got_v);
		if (exp_v !== got_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_v, got_v);
			fail_cnt++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CAPACITY; i++)
				slot_hash[i] = '0;
			used_slots = 0;
			answer_q.delete();
			pending_cnt <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (answer_q.size() == 0) begin
					$display("%0t: response beat with nothing expected, actual value %0h",
						$time, result_value);
					fail_cnt++;
				end else begin
					want = answer_q.pop_front();
					check_word("result_value", want.value, result_value);
					check_word("found", want.hit, found);
					check_word("table_full", want.full, table_full);
					check_word("load_high", want.load, load_high);
				end
			end
			if (req_valid && !req_stall)
				answer_q.push_back(probe_table(mode, key, key_hash, new_value, default_value));
			pending_cnt <= answer_q.size();
		end
	end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the hash map core. The checker beside the block
// predicts every response; this module only drives beats and pacing.
module tb_top;
	import hmap_pkg::*;

	localparam int POOL        = 24;    // keys the random part draws from
	localparam int RAND_ITEMS  = 1725;
	localparam int HOLD_CYCLES = 400;   // long response hold-off
	localparam int QUIET_LIMIT = 3000;  // cycles with no beat before giving up
	localparam int DRAIN       = 40;    // extra wait after the checker has nothing pending

	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic              req_valid     = 1'b0;
	logic              req_stall;
	logic              mode          = MODE_GET;
	logic [WORD_W-1:0] key           = '0;
	logic [WORD_W-1:0] key_hash      = '0;
	logic [WORD_W-1:0] new_value     = '0;
	logic [WORD_W-1:0] default_value = '0;
	logic              rsp_valid;
	logic              rsp_stall     = 1'b0;
	logic [WORD_W-1:0] result_value;
	logic              found;
	logic              table_full;
	logic              load_high;

	int fail_cnt;
	int pending_cnt;

	// Pacing knobs, written by the main sequence with nonblocking updates so
	// the response side sees them at a well-defined edge.
	int req_idle_pct = 26;
	int rsp_idle_pct = 64;
	int hold_asked   = 0;
	int hold_seen    = 0;
	int hold_left    = 0;
	int quiet_cycles = 0;
	int puts_sent    = 0;
	int gets_sent    = 0;

	// Key pool: resident keys, colliding hashes and keys that stay absent.
	logic [WORD_W-1:0] pool_key  [POOL];
	logic [WORD_W-1:0] pool_hash [POOL];

	always #4 clk = ~clk;

	open_addressed_hash_map_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.mode          (mode),
		.key           (key),
		.key_hash      (key_hash),
		.new_value     (new_value),
		.default_value (default_value),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.result_value  (result_value),
		.found         (found),
		.table_full    (table_full),
		.load_high     (load_high)
	);

	hmap_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.mode          (mode),
		.key           (key),
		.key_hash      (key_hash),
		.new_value     (new_value),
		.default_value (default_value),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.result_value  (result_value),
		.found         (found),
		.table_full    (table_full),
		.load_high     (load_high),
		.fail_cnt      (fail_cnt),
		.pending_cnt   (pending_cnt)
	);

	// Response side: a requested hold-off wins over the random stall.
	// The hold is counted here so the request side keeps offering beats
	// and the core backs up into req_stall.
	always @(posedge clk) begin
		if (hold_seen != hold_asked) begin
			hold_seen <= hold_asked;
			hold_left <= HOLD_CYCLES;
			rsp_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
		end
	end

	// Watchdog: any accepted beat on either channel resets the count.
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
			$display("Some tests failed");
			$finish;
		end
	end

	// One request beat. Optional idle cycles first; valid is only lowered
	// when a gap is actually taken, and the payload holds while stalled.
	task automatic send_request(input logic m, input logic [WORD_W-1:0] k,
			input logic [WORD_W-1:0] h, input logic [WORD_W-1:0] nv,
			input logic [WORD_W-1:0] dv);
		while ($urandom_range(99) < req_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid     <= 1'b1;
		mode          <= m;
		key           <= k;
		key_hash      <= h;
		new_value     <= nv;
		default_value <= dv;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		if (m == MODE_PUT)
			puts_sent++;
		else
			gets_sent++;
	endtask

	initial begin
		logic [WORD_W-1:0] k;
		logic [WORD_W-1:0] h;
		logic              m;
		int                idx;

		for (int i = 0; i < POOL; i++) begin
			pool_key[i]  = {$urandom, $urandom};
			pool_hash[i] = {$urandom, $urandom};
		end
		pool_key[1]  = '0;          // zero key with zero hash (remapped to one)
		pool_hash[1] = '0;
		pool_key[2]  = '1;          // all-ones key and hash
		pool_hash[2] = '1;
		pool_hash[3] = pool_hash[0];  // same hash as entry 0, other key
		pool_hash[4] = pool_hash[0];  // never stored, same hash again
		// 17..23 are never stored: odd ones copy a resident's full hash,
		// even ones only its start slot
		for (int i = 17; i < POOL; i++) begin
			if (i % 2)
				pool_hash[i] = pool_hash[i - 12];
			else
				pool_hash[i][3:0] = pool_hash[i - 12][3:0];
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed part ----
		// get on an empty table stops at the first, free slot
		send_request(MODE_GET, pool_key[0], pool_hash[0], '0, '1);
		// insert with all-ones value, then update to zero
		send_request(MODE_PUT, pool_key[0], pool_hash[0], '1, '0);
		send_request(MODE_PUT, pool_key[0], pool_hash[0], '0, '1);
		send_request(MODE_GET, pool_key[0], pool_hash[0], '1, '1);
		// same key, other hash with the same start slot: probes past, misses
		send_request(MODE_GET, pool_key[0],
			{pool_hash[0][WORD_W-1:4] ^ 60'h1, pool_hash[0][3:0]}, '0, '0);
		// zero hash is stored as one, so a get with hash one finds it
		send_request(MODE_PUT, pool_key[1], pool_hash[1], {$urandom, $urandom}, '0);
		send_request(MODE_GET, pool_key[1], 64'd1, '0, '1);
		send_request(MODE_PUT, pool_key[2], pool_hash[2], {$urandom, $urandom}, '1);
		// same full hash, different key: probes past entry 0
		send_request(MODE_PUT, pool_key[3], pool_hash[3], {$urandom, $urandom}, '0);
		send_request(MODE_GET, pool_key[4], pool_hash[4], '1, {$urandom, $urandom});
		// fill the remaining twelve slots; load mark trips at twelve used
		for (int i = 5; i < 17; i++)
			send_request(MODE_PUT, pool_key[i], pool_hash[i], {$urandom, $urandom}, '0);
		// table full: new key is refused, absent key walks every slot,
		// existing key still updates
		send_request(MODE_PUT, pool_key[17], pool_hash[17], {$urandom, $urandom}, '0);
		send_request(MODE_GET, pool_key[18], pool_hash[18], '0, {$urandom, $urandom});
		send_request(MODE_PUT, pool_key[0], pool_hash[0], {$urandom, $urandom}, '0);

		// ---- random part ----
		// mostly pool keys (hits, updates, collisions), some fresh noise keys
		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n == RAND_ITEMS / 3) begin
				req_idle_pct <= 64;
				rsp_idle_pct <= 26;
			end else if (n == 2 * RAND_ITEMS / 3) begin
				req_idle_pct <= 0;
				rsp_idle_pct <= 0;
				hold_asked   <= hold_asked + 1;
			end
			if ($urandom_range(99) < 80) begin
				idx = $urandom_range(POOL - 1);
				k   = pool_key[idx];
				h   = pool_hash[idx];
				if (idx == 1 && $urandom_range(1))
					h = 64'd1;
			end else begin
				k = {$urandom, $urandom};
				h = {$urandom, $urandom};
			end
			m = $urandom_range(1) ? MODE_PUT : MODE_GET;
			send_request(m, k, h, {$urandom, $urandom}, {$urandom, $urandom});
		end
		req_valid <= 1'b0;

		// drain; the watchdog bounds this wait
		while (pending_cnt != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("Covered %0d gets and %0d puts: empty, filling and full table,",
			gets_sent, puts_sent);
		$display("zero and colliding hashes, random stalls both ways, %0d-cycle hold-off.",
			HOLD_CYCLES);
		if (fail_cnt == 0 && pending_cnt == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
